/* src/integer_literal_parser_defines.svh */
// Assertion macros for the integer literal parser.
// Depends on nothing; included by the modules that carry assertions.
`ifndef INTEGER_LITERAL_PARSER_DEFINES_SVH
`define INTEGER_LITERAL_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define ILP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integer_literal_parser: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define ILP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integer_literal_parser: next-cycle check failed");

`endif

/* src/ilp_pkg.sv */
// Package for the integer literal parser: payload structs, scan codes,
// character constants and digit helpers. Depends on nothing.
package ilp_pkg;

    // Characters the scanner reacts to
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    // Largest magnitude that still takes one more hex digit
    localparam logic [63:0] HEX_SAFE = 64'h0FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_DEC    = 2'd1,
        PH_PREFIX = 2'd2,
        PH_HEX    = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_NUM   = 2'd1,
        ERR_HEX   = 2'd2,
        ERR_RANGE = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD_NUM = 3'd1,
        ST_BAD_HEX = 3'd2,
        ST_RANGE   = 3'd3,
        ST_FLOAT   = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] int_value;
        t_status            status;
    } t_out_item;

    // Result as held in the output stage: magnitude and sign, negated on the way out
    typedef struct packed {
        logic [63:0] mag;
        logic        neg;
        t_status     status;
    } t_res;

    function automatic logic is_dec_digit(input logic [7:0] c);
        return c inside {[CH_0:CH_9]};
    endfunction

    function automatic logic is_hex_digit(input logic [7:0] c);
        return c inside {[CH_0:CH_9], [CH_LO_A:CH_LO_F], [CH_UP_A:CH_UP_F]};
    endfunction

    // Nibble value of a valid hex digit; letters sit at 1..6 in their low nibble
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] v;
        if (is_dec_digit(c)) begin
            v = c[3:0];
        end else begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    function automatic logic is_float_mark(input logic [7:0] c);
        return (c == CH_DOT) || (c == CH_LO_E) || (c == CH_UP_E);
    endfunction

endpackage

/* src/integer_literal_parser.sv */
// Integer literal parser top level: character input register, scan state,
// result register with skid. Depends on ilp_pkg and integer_literal_parser_defines.svh.
//
//   channel | valid      | ready       | payload
//   --------+------------+-------------+-------------------------------------
//   input   | i_in_valid | o_in_ready  | i_in_data  (char_code, last_char)
//   result  | o_out_valid| i_out_ready | o_out_data (int_value, status)
//
// One character per cycle, but a final character can wait for the output stage.
// A transferred character is held in the input register and scanned from there;
// a token's result enters the output stage with its last character. The scan state update
// (one multiply-by-ten add) sets the pace. Reset is synchronous; there is no clearing pass.
// A two-entry output stage absorbs a stalled consumer; only a final character
// waits, and only while both output entries are full.
`include "integer_literal_parser_defines.svh"

module integer_literal_parser
    import ilp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // Input register
    t_in_item    r_in;
    logic        r_in_valid;

    // Scan state
    logic [63:0] r_mag, n_mag;
    logic        r_neg, n_neg;
    t_phase      r_phase, n_phase;
    logic [1:0]  r_idx, n_idx;
    t_err        r_err, n_err;
    logic        r_float, n_float;
    logic        r_latched, n_latched;

    // State after this character, before the end-of-token clear
    logic [63:0] upd_mag;
    logic        upd_neg;
    t_phase      upd_phase;
    logic [1:0]  upd_idx;
    t_err        upd_err;
    logic        upd_float;
    logic        upd_latched;

    // Output stage
    t_res        r_out, r_skid, res;
    logic        r_out_valid, r_skid_valid;

    logic        advance, emit;
    logic [7:0]  ch;
    t_phase      eff_phase;
    logic        is_prefix;
    logic [3:0]  dec_digit;
    logic [67:0] dec_sum;
    logic [63:0] hex_base;
    logic        hex_base_latched;
    logic        over_limit;
    t_status     fin_status;

    // Check helpers
    logic        scan_idle;
    logic        out_err;

    // Handshake: a final character waits only for a free output entry
    assign advance    = r_in_valid && (!r_in.last_char || !r_skid_valid);
    assign emit       = advance && r_in.last_char;
    assign o_in_ready = !r_in_valid || advance;
    assign ch         = r_in.char_code;

    // Hold the incoming character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
            if (i_in_valid) begin
                r_in <= i_in_data;
            end
        end
    end

    // Datapath helpers
    assign eff_phase        = (r_phase == PH_START) ? PH_DEC : r_phase;
    assign dec_digit        = ch[3:0];
    assign dec_sum          = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1) + {64'b0, dec_digit};
    assign hex_base         = (eff_phase == PH_PREFIX) ? 64'd0 : r_mag;
    assign hex_base_latched = (eff_phase == PH_PREFIX) ? 1'b0 : r_latched;
    assign is_prefix        = (r_idx == 2'd1) && (ch inside {CH_LO_X, CH_UP_X})
                              && (r_mag == 64'd0) && !r_latched && !r_float;

    // Advance the scan by one character
    always_comb begin
        upd_mag     = r_mag;
        upd_neg     = r_neg;
        upd_phase   = r_phase;
        upd_idx     = r_idx;
        upd_err     = r_err;
        upd_float   = r_float;
        upd_latched = r_latched;
        if (r_phase == PH_START && (ch inside {CH_PLUS, CH_MINUS})) begin
            upd_neg   = (ch == CH_MINUS);
            upd_phase = PH_DEC;
            upd_idx   = 2'd0;
        end else begin
            if (eff_phase == PH_PREFIX || eff_phase == PH_HEX) begin
                // Hex digit; entering from the prefix drops the decimal view
                upd_phase   = PH_HEX;
                upd_mag     = hex_base;
                upd_latched = hex_base_latched;
                if (eff_phase == PH_PREFIX) begin
                    upd_err   = ERR_NONE;
                    upd_float = 1'b0;
                end
                if (!hex_base_latched) begin
                    if (!is_hex_digit(ch)) begin
                        upd_latched = 1'b1;
                        upd_err     = ERR_HEX;
                    end else if (hex_base > HEX_SAFE) begin
                        upd_latched = 1'b1;
                        upd_err     = ERR_RANGE;
                    end else begin
                        upd_mag = {hex_base[59:0], hex_nibble(ch)};
                    end
                end
            end else begin
                // Decimal digit; float marks are noted even after an error
                upd_phase = is_prefix ? PH_PREFIX : PH_DEC;
                if (is_float_mark(ch)) begin
                    upd_float = 1'b1;
                end
                if (!r_latched) begin
                    if (!is_dec_digit(ch)) begin
                        upd_latched = 1'b1;
                        upd_err     = ERR_NUM;
                    end else if (|dec_sum[67:64]) begin
                        upd_latched = 1'b1;
                        upd_err     = ERR_RANGE;
                    end else begin
                        upd_mag = dec_sum[63:0];
                    end
                end
            end
            if (r_idx != 2'd3) begin
                upd_idx = r_idx + 2'd1;
            end
        end
    end

    // Form the token result
    always_comb begin
        over_limit = upd_neg ? (upd_mag[63] && (|upd_mag[62:0])) : upd_mag[63];
        if (upd_phase != PH_HEX && upd_float) begin
            fin_status = ST_FLOAT;
        end else begin
            case (upd_err)
                ERR_NUM:   fin_status = ST_BAD_NUM;
                ERR_HEX:   fin_status = ST_BAD_HEX;
                ERR_RANGE: fin_status = ST_RANGE;
                default:   fin_status = over_limit ? ST_RANGE : ST_OK;
            endcase
        end
        res.status = fin_status;
        res.neg    = upd_neg;
        res.mag    = (fin_status == ST_OK) ? upd_mag : 64'd0;
    end

    // Clear the scan after the final character
    always_comb begin
        if (r_in.last_char) begin
            n_mag     = 64'd0;
            n_neg     = 1'b0;
            n_phase   = PH_START;
            n_idx     = 2'd0;
            n_err     = ERR_NONE;
            n_float   = 1'b0;
            n_latched = 1'b0;
        end else begin
            n_mag     = upd_mag;
            n_neg     = upd_neg;
            n_phase   = upd_phase;
            n_idx     = upd_idx;
            n_err     = upd_err;
            n_float   = upd_float;
            n_latched = upd_latched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag     <= 64'd0;
            r_neg     <= 1'b0;
            r_phase   <= PH_START;
            r_idx     <= 2'd0;
            r_err     <= ERR_NONE;
            r_float   <= 1'b0;
            r_latched <= 1'b0;
        end else if (advance) begin
            r_mag     <= n_mag;
            r_neg     <= n_neg;
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_err     <= n_err;
            r_float   <= n_float;
            r_latched <= n_latched;
        end
    end

    // Output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && i_out_ready) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (emit) begin
                r_out <= res;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (emit) begin
            if (r_out_valid) begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end else begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end
        end
    end

    // Apply the sign on the way out
    assign o_out_valid           = r_out_valid;
    assign o_out_data.int_value  = r_out.neg ? $signed(64'd0 - r_out.mag) : $signed(r_out.mag);
    assign o_out_data.status     = r_out.status;

    // Checks
    assign scan_idle = (r_phase == PH_START) && (r_mag == 64'd0) && !r_latched;
    assign out_err   = o_out_valid && (o_out_data.status != ST_OK);

    `ILP_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ILP_ASSERT_IMP(a_no_emit_when_full, i_clk, i_rst_n, emit, !r_skid_valid)
    `ILP_ASSERT_IMP(a_latch_matches_err, i_clk, i_rst_n, 1'b1, r_latched == (r_err != ERR_NONE))
    `ILP_ASSERT_IMP(a_hex_no_float, i_clk, i_rst_n, r_phase == PH_HEX, !r_float)
    `ILP_ASSERT_NXT(a_clear_after_token, i_clk, i_rst_n, emit, scan_idle)
    `ILP_ASSERT_IMP(a_zero_unless_ok, i_clk, i_rst_n, out_err, o_out_data.int_value == 64'sd0)

endmodule

/* bench/tb_integer_literal_parser.sv */
// Self-checking testbench for integer_literal_parser: streams numeric tokens
// one character per transfer and scores every result against a local model.
// Depends on ilp_pkg and the integer_literal_parser RTL.
module tb_integer_literal_parser;
    import ilp_pkg::*;

    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SIGN_LIMIT  = 64'h8000_0000_0000_0000;
    localparam int          CHAR_TARGET = 1250;
    localparam int          HOLD_AT     = 1000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          REPORT_MAX  = 10;

    // Token scanner model and queue of pending parse results
    class literal_result_board;
        logic [63:0] mag;
        logic        neg;
        t_phase      phase;
        logic [1:0]  idx;
        t_err        ferr;
        logic        fseen;
        logic        halted;
        t_out_item   expected_values[$];
        int          errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            mag    = '0;
            neg    = 1'b0;
            phase  = PH_START;
            idx    = '0;
            ferr   = ERR_NONE;
            fseen  = 1'b0;
            halted = 1'b0;
        endfunction

        function void latch_err(t_err code);
            halted = 1'b1;
            ferr   = code;
        endfunction

        function void dec_digit(logic [7:0] c);
            logic [63:0] d;
            if (c == CH_DOT || c == CH_LO_E || c == CH_UP_E) begin
                fseen = 1'b1;
            end
            if (!halted) begin
                if (c >= CH_0 && c <= CH_9) begin
                    d = 64'(c - CH_0);
                    if (mag > (ALL_ONES - d) / 64'd10) begin
                        latch_err(ERR_RANGE);
                    end else begin
                        mag = mag * 64'd10 + d;
                    end
                end else begin
                    latch_err(ERR_NUM);
                end
            end
        endfunction

        function void hex_digit(logic [7:0] c);
            int h;
            h = -1;
            if (!halted) begin
                if (c >= CH_0 && c <= CH_9) begin
                    h = int'(c - CH_0);
                end else if (c >= CH_LO_A && c <= CH_LO_F) begin
                    h = int'(c - CH_LO_A) + 10;
                end else if (c >= CH_UP_A && c <= CH_UP_F) begin
                    h = int'(c - CH_UP_A) + 10;
                end
                if (h < 0) begin
                    latch_err(ERR_HEX);
                end else if (mag > HEX_SAFE) begin
                    latch_err(ERR_RANGE);
                end else begin
                    mag = mag * 64'd16 + 64'(h);
                end
            end
        endfunction

        // Advance the scan by one accepted character; queue a result on the last one
        function void note_char(t_in_item it);
            logic [7:0]  c;
            logic        pfx;
            logic [63:0] limit;
            t_out_item   res;
            c = it.char_code;
            if (phase == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
                neg   = (c == CH_MINUS);
                phase = PH_DEC;
                idx   = '0;
            end else begin
                if (phase == PH_START) begin
                    phase = PH_DEC;
                end
                if (phase == PH_PREFIX) begin
                    phase  = PH_HEX;
                    mag    = '0;
                    ferr   = ERR_NONE;
                    halted = 1'b0;
                    fseen  = 1'b0;
                    hex_digit(c);
                end else if (phase == PH_HEX) begin
                    hex_digit(c);
                end else begin
                    pfx = (idx == 2'd1) && (c == CH_LO_X || c == CH_UP_X) &&
                          (mag == '0) && !halted && !fseen;
                    dec_digit(c);
                    if (pfx) begin
                        phase = PH_PREFIX;
                    end
                end
                if (idx != 2'd3) begin
                    idx = idx + 2'd1;
                end
            end

            if (it.last_char) begin
                limit         = neg ? SIGN_LIMIT : SIGN_LIMIT - 64'd1;
                res.int_value = '0;
                if (phase != PH_HEX && fseen) begin
                    res.status = ST_FLOAT;
                end else if (ferr != ERR_NONE) begin
                    case (ferr)
                        ERR_NUM: res.status = ST_BAD_NUM;
                        ERR_HEX: res.status = ST_BAD_HEX;
                        default: res.status = ST_RANGE;
                    endcase
                end else if (mag > limit) begin
                    res.status = ST_RANGE;
                end else begin
                    res.status    = ST_OK;
                    res.int_value = neg ? (64'd0 - mag) : mag;
                end
                expected_values.push_back(res);
                clear();
            end
        endfunction

        // Compare one transferred result with the oldest pending one
        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_values.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX) begin
                    $display("unexpected result: value %0d status %0d",
                             got.int_value, got.status);
                end
            end else begin
                want = expected_values.pop_front();
                if (got.int_value !== want.int_value || got.status !== want.status) begin
                    errors++;
                    if (errors <= REPORT_MAX) begin
                        $display("mismatch: value %0d status %0d, wanted value %0d status %0d",
                                 got.int_value, got.status, want.int_value, want.status);
                    end
                end
            end
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    literal_result_board board;
    logic [7:0]          token[$];
    int                  chars_sent = 0;
    bit                  quiet_token = 1'b0;

    integer_literal_parser i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pick an idle length: mostly none or short, a few long
    function int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one character and hold it until the transfer
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = quiet_token ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{char_code: c, last_char: last};
        do @(posedge i_clk); while (!o_in_ready);
        board.note_char('{char_code: c, last_char: last});
        chars_sent++;
    endtask

    task automatic send_token();
        quiet_token = ($urandom_range(0, 3) == 0);
        foreach (token[i]) begin
            send_char(token[i], i == token.size() - 1);
        end
    endtask

    function void push_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            token.push_back(s[i]);
        end
    endfunction

    function void push_sign();
        case ($urandom_range(0, 2))
            0: ;
            1: token.push_back(CH_PLUS);
            default: token.push_back(CH_MINUS);
        endcase
    endfunction

    function void push_dec(int n);
        for (int i = 0; i < n; i++) begin
            token.push_back(CH_0 + 8'($urandom_range(0, 9)));
        end
    endfunction

    function void push_hex(int n);
        string digits;
        digits = "0123456789abcdefABCDEF";
        for (int i = 0; i < n; i++) begin
            token.push_back(digits[$urandom_range(0, digits.len() - 1)]);
        end
    endfunction

    // Build one random token; most are well formed with random content
    function void make_token();
        string edges[6];
        int    kind;
        int    n;
        edges = '{"9223372036854775807", "9223372036854775808", "18446744073709551615",
                  "18446744073709551616", "99999999999999999999", "0000000000000000000001"};
        token.delete();
        kind = $urandom_range(0, 99);
        if (kind < 30 || (kind >= 75 && kind < 81)) begin
            push_sign();
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 21) : $urandom_range(1, 8);
            push_dec(n);
        end else if (kind < 42) begin
            push_sign();
            push_text(edges[$urandom_range(0, 5)]);
        end else if (kind < 65 || (kind >= 81 && kind < 87)) begin
            push_sign();
            token.push_back(CH_0);
            token.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 17) : $urandom_range(1, 6);
            if (n == 16 && $urandom_range(0, 1)) begin
                token.push_back($urandom_range(0, 1) ? 8'h38 : CH_UP_F);
                n--;
            end
            push_hex(n);
        end else if (kind < 75) begin
            push_sign();
            push_dec($urandom_range(0, 6));
            case ($urandom_range(0, 2))
                0: token.push_back(CH_DOT);
                1: token.push_back(CH_LO_E);
                default: token.push_back(CH_UP_E);
            endcase
            push_dec($urandom_range(0, 4));
            if ($urandom_range(0, 3) == 0) begin
                token.push_back(8'($urandom_range(0, 255)));
            end
        end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                token.push_back(8'($urandom_range(0, 255)));
            end
        end
        // Corrupt one character of a well-formed token
        if (kind >= 75 && kind < 87) begin
            token[$urandom_range(0, token.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endfunction

    // Receiver: random back-pressure plus one long hold-off
    initial begin
        int rx_cycle;
        int stall_left;
        int burst_left;
        int r;
        rx_cycle   = 0;
        stall_left = 0;
        burst_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                board.check_result(o_out_data);
            end
            rx_cycle++;
            if (rx_cycle == HOLD_AT) begin
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    burst_left = $urandom_range(20, 80);
                    i_out_ready <= 1'b1;
                end else if (r < 75) begin
                    i_out_ready <= 1'b1;
                end else if (r < 95) begin
                    stall_left = $urandom_range(0, 2);
                    i_out_ready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(10, 40);
                    i_out_ready <= 1'b0;
                end
            end
        end
    end

    // Abort a hung run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[integer_literal_parser] ERROR");
        $finish;
    end

    initial begin
        string directed[10];
        directed = '{"+", "-", "0x", "-0x", "1e", "+-", "0xE.", "0xaF", "7", "X"};
        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: sign only, bare prefix, late sign, hex letters and dot, odd bytes
        foreach (directed[i]) begin
            token.delete();
            push_text(directed[i]);
            send_token();
        end
        token.delete();
        token.push_back(8'h00);
        send_token();
        token.delete();
        token.push_back(8'hFF);
        send_token();

        while (chars_sent < CHAR_TARGET) begin
            make_token();
            send_token();
        end
        i_in_valid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (board.expected_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0 && board.expected_values.size() == 0) begin
            $display("[integer_literal_parser] OK");
        end else begin
            $display("[integer_literal_parser] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/ilp_pkg.sv
src/integer_literal_parser.sv
bench/tb_integer_literal_parser.sv
